>>> hdl/bpc_pkg.sv
package bpc_pkg;

   // Fixed-point format of the scaled samples and the Horner terms
   localparam int Q_FRAC     = 24;
   localparam int HALF_Q     = 1 << (Q_FRAC - 1);
   localparam int P_W        = 32;  // scaled pressure / temperature
   localparam int RECIP_W    = 32;  // unsigned reciprocal, top bit always clear
   localparam int RAW_PORT_W = 24;  // raw field width on the bus

   // Temperature output: c0*128 + round(c1*t / 2^16)
   localparam int TEMP_W       = 26;
   localparam int TEMP_SHIFT   = 16;
   localparam int HALF_T       = 1 << (TEMP_SHIFT - 1);
   localparam int TEMP_C0_SHFT = 7;

   // Pressure output: round(sum / 2^18), saturated to 40 bits
   localparam int PRES_W     = 40;
   localparam int PRES_SHIFT = 18;
   localparam int HALF_P     = 1 << (PRES_SHIFT - 1);
   localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
   localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

   // Datapath widths of the polynomial pipeline
   localparam int MA_W  = 16 + P_W;            // c30*p, c21*p
   localparam int MT_W  = 12 + P_W;            // c1*t
   localparam int A1_W  = 48;                  // first Horner term
   localparam int MH1_W = (A1_W - Q_FRAC) + P_W;
   localparam int ML_W  = (Q_FRAC + 1) + P_W;  // low part times p or t
   localparam int A2_W  = 52;                  // second Horner term
   localparam int MH2_W = (A2_W - Q_FRAC) + P_W;
   localparam int A3_W  = 56;                  // final products
   localparam int SUM_W = 58;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_OFFSET_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESSURE_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESSURE_LINEAR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CROSS_TERMS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_QUADRATIC_TERMS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CUBIC_TERM       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OVERSAMPLING_SEL = 3'd6;

   typedef logic signed [P_W-1:0] sample_type;

   // Unpacked compensation coefficients
   typedef struct packed {
      logic signed [11:0] c0;
      logic signed [11:0] c1;
      logic signed [19:0] c00;
      logic signed [19:0] c10;
      logic signed [15:0] c01;
      logic signed [15:0] c11;
      logic signed [15:0] c20;
      logic signed [15:0] c21;
      logic signed [15:0] c30;
   } coef_type;

   // round(2^48 / scale factor) for each oversampling code
   function automatic logic [RECIP_W-1:0] recip(input logic [2:0] code);
      logic [RECIP_W-1:0] r;
      case (code)
         3'd0: r = 32'd536870912;
         3'd1: r = 32'd178956971;
         3'd2: r = 32'd76695845;
         3'd3: r = 32'd35791394;
         3'd4: r = 32'd1108378657;
         3'd5: r = 32'd545392673;
         3'd6: r = 32'd270549121;
         3'd7: r = 32'd134744072;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/baro_pressure_temp_compensation_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: raw_pressure, raw_temperature
// rsp      out        rsp_tvalid/rsp_tready  tdata: temperature_out, pressure_out;
//                                            tuser: saturated
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One sample pair per cycle while rsp is not stalled; on the way to rsp_tvalid a pair passes
// two scaling stages, six polynomial stages, one output stage; the transfer loads the first.
// Depth is set by the split multiplies of the Horner chain, one stage each.
// Reset is synchronous, active high; it clears valid bits and the coefficient registers.
// When rsp is stalled the whole pipeline holds; one input skid register keeps req_tready
// a registered signal and takes one more transfer during the stall.
// csr_ready is always high; writes are expected only while the block is idle.
module baro_pressure_temp_compensation_core #(
   parameter int RAW_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [25:0] temperature_out, [65:26] pressure_out, zeros
   output logic        rsp_tuser,   // [0] saturated

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bpc_pkg::*;

   // Coefficient and oversampling registers
   logic [23:0] tog_ff;
   logic [19:0] poff_ff;
   logic [19:0] plin_ff;
   logic [31:0] cross_ff;
   logic [31:0] quad_ff;
   logic [15:0] cubic_ff;
   logic [5:0]  osr_ff;
   coef_type    coef;

   // Input skid
   logic                  skid_valid_ff, skid_valid_in;
   logic [47:0]           skid_data_ff;
   logic                  req_xfer;
   logic                  feed_valid;
   logic [47:0]           feed_data;
   logic                  pipe_en;

   // Stage outputs
   logic                  sc_valid;
   sample_type            sc_p, sc_t;
   logic                  pl_valid;
   logic signed [TEMP_W-1:0] pl_temp;
   logic signed [A3_W-1:0]   pl_a3, pl_b3;

   // Output stage
   logic signed [SUM_W-1:0]  pres_sum, pres_rnd;
   logic                     sat_hi, sat_lo;
   logic signed [PRES_W-1:0] pres_in;
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [PRES_W-1:0] pres_ff;
   logic                     sat_ff;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tog_ff   <= '0;
         poff_ff  <= '0;
         plin_ff  <= '0;
         cross_ff <= '0;
         quad_ff  <= '0;
         cubic_ff <= '0;
         osr_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TEMP_OFFSET_GAIN: tog_ff   <= csr_data[23:0];
            REG_PRESSURE_OFFSET:  poff_ff  <= csr_data[19:0];
            REG_PRESSURE_LINEAR:  plin_ff  <= csr_data[19:0];
            REG_CROSS_TERMS:      cross_ff <= csr_data;
            REG_QUADRATIC_TERMS:  quad_ff  <= csr_data;
            REG_CUBIC_TERM:       cubic_ff <= csr_data[15:0];
            REG_OVERSAMPLING_SEL: osr_ff   <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Coefficient unpacking
   always_comb begin
      coef.c0  = tog_ff[23:12];
      coef.c1  = tog_ff[11:0];
      coef.c00 = poff_ff;
      coef.c10 = plin_ff;
      coef.c01 = cross_ff[31:16];
      coef.c11 = cross_ff[15:0];
      coef.c20 = quad_ff[31:16];
      coef.c21 = quad_ff[15:0];
      coef.c30 = cubic_ff;
   end

   // Global advance: output register empty or being drained
   assign pipe_en = !rsp_valid_ff || rsp_tready;

   // Input skid: catches one transfer while the pipeline holds
   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign feed_valid = skid_valid_ff || req_xfer;
   assign feed_data  = skid_valid_ff ? skid_data_ff : req_tdata;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (pipe_en) begin
         skid_valid_in = 1'b0;
      end else if (req_xfer) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && req_xfer) begin
         skid_data_ff <= req_tdata;
      end
   end

   bpc_scale #(
      .RAW_WIDTH (RAW_WIDTH)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .en_i    (pipe_en),
      .valid_i (feed_valid),
      .raw_p_i (feed_data[RAW_PORT_W-1:0]),
      .raw_t_i (feed_data[2*RAW_PORT_W-1:RAW_PORT_W]),
      .osr_p_i (osr_ff[5:3]),
      .osr_t_i (osr_ff[2:0]),
      .valid_o (sc_valid),
      .p_o     (sc_p),
      .t_o     (sc_t)
   );

   bpc_poly u_poly (
      .clock   (clock),
      .reset   (reset),
      .en_i    (pipe_en),
      .valid_i (sc_valid),
      .p_i     (sc_p),
      .t_i     (sc_t),
      .coef_i  (coef),
      .valid_o (pl_valid),
      .temp_o  (pl_temp),
      .a3_o    (pl_a3),
      .b3_o    (pl_b3)
   );

   // Final sum, rounding to 1/64 Pa and clipping
   assign pres_sum = SUM_W'(signed'({coef.c00, {Q_FRAC{1'b0}}}))
                   + SUM_W'(pl_a3) + SUM_W'(pl_b3);
   assign pres_rnd = (pres_sum + SUM_W'(HALF_P)) >>> PRES_SHIFT;
   assign sat_hi   = pres_rnd > SUM_W'(PRES_MAX);
   assign sat_lo   = pres_rnd < SUM_W'(PRES_MIN);

   always_comb begin
      pres_in = pres_rnd[PRES_W-1:0];
      if (sat_hi) begin
         pres_in = PRES_MAX;
      end else if (sat_lo) begin
         pres_in = PRES_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= pl_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         temp_ff <= pl_temp;
         pres_ff <= pres_in;
         sat_ff  <= sat_hi || sat_lo;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, pres_ff, temp_ff};
   assign rsp_tuser  = sat_ff;

   // Skid fills only on a transfer taken while the pipeline holds
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff)) |-> $past(!pipe_en && req_tvalid))
      else $error("skid loaded while pipeline advancing");

   // A held item leaves the skid as soon as the pipeline advances
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pipe_en) |=> !skid_valid_ff)
      else $error("skid not drained on advance");

   // A clipped result sits exactly on a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> (pres_ff == PRES_MAX || pres_ff == PRES_MIN))
      else $error("saturation flag without clipped pressure");

endmodule

>>> hdl/bpc_scale.sv
module bpc_scale #(
   parameter int RAW_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en_i,
   input  logic                  valid_i,
   input  logic [23:0]           raw_p_i,
   input  logic [23:0]           raw_t_i,
   input  logic [2:0]            osr_p_i,
   input  logic [2:0]            osr_t_i,
   output logic                  valid_o,
   output bpc_pkg::sample_type   p_o,
   output bpc_pkg::sample_type   t_o
);
   import bpc_pkg::*;

   localparam int PROD_W = RAW_WIDTH + RECIP_W;

   logic signed [RAW_WIDTH-1:0] rp, rt;
   logic signed [RECIP_W-1:0]   recip_p, recip_t;
   logic signed [PROD_W-1:0]    prod_p_in, prod_t_in, prod_p_ff, prod_t_ff;
   logic signed [PROD_W-1:0]    rnd_p, rnd_t;
   sample_type                  p_ff, t_ff;
   logic                        v1_ff, v2_ff;

   // Sign-extend from the configured raw width
   assign rp = raw_p_i[RAW_WIDTH-1:0];
   assign rt = raw_t_i[RAW_WIDTH-1:0];

   // Stage 1: multiply by the reciprocal of the oversampling factor
   assign recip_p   = signed'(recip(osr_p_i));
   assign recip_t   = signed'(recip(osr_t_i));
   assign prod_p_in = PROD_W'(rp * recip_p);
   assign prod_t_in = PROD_W'(rt * recip_t);

   // Stage 2: round half up back to Q24
   assign rnd_p = (prod_p_ff + PROD_W'(HALF_Q)) >>> Q_FRAC;
   assign rnd_t = (prod_t_ff + PROD_W'(HALF_Q)) >>> Q_FRAC;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en_i) begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         prod_p_ff <= prod_p_in;
         prod_t_ff <= prod_t_in;
         p_ff      <= rnd_p[P_W-1:0];
         t_ff      <= rnd_t[P_W-1:0];
      end
   end

   assign valid_o = v2_ff;
   assign p_o     = p_ff;
   assign t_o     = t_ff;

endmodule

>>> hdl/bpc_poly.sv
module bpc_poly (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en_i,
   input  logic                        valid_i,
   input  bpc_pkg::sample_type         p_i,
   input  bpc_pkg::sample_type         t_i,
   input  bpc_pkg::coef_type           coef_i,
   output logic                        valid_o,
   output logic signed [25:0]          temp_o,
   output logic signed [55:0]          a3_o,
   output logic signed [55:0]          b3_o
);
   import bpc_pkg::*;

   // Valid bits of stages 3 to 8
   logic [5:0] v_ff;

   // Stage 3: first products
   logic signed [MA_W-1:0]   ma3_in, mb3_in, ma3_ff, mb3_ff;
   logic signed [MT_W-1:0]   mt3_in, mt3_ff;
   sample_type               p3_ff, t3_ff;

   // Stage 4: first Horner terms and temperature
   logic signed [A1_W-1:0]   a1_in, b1_in, a1_ff, b1_ff;
   logic signed [MT_W-1:0]   mt_rnd;
   logic signed [TEMP_W-1:0] temp4_in, temp4_ff;
   sample_type               p4_ff, t4_ff;

   // Stage 5: split products of the first terms with p
   logic signed [MH1_W-1:0]  mah5_in, mbh5_in, mah5_ff, mbh5_ff;
   logic signed [ML_W-1:0]   mal5_in, mbl5_in, mal5_ff, mbl5_ff;
   logic signed [TEMP_W-1:0] temp5_ff;
   sample_type               p5_ff, t5_ff;

   // Stage 6: second Horner terms
   logic signed [ML_W-1:0]   a2_sum, b2_sum;
   logic signed [A2_W-1:0]   a2_ff, b2_ff;
   logic signed [TEMP_W-1:0] temp6_ff;
   sample_type               p6_ff, t6_ff;

   // Stage 7: split products, a with p and b with t
   logic signed [MH2_W-1:0]  mah7_in, mbh7_in, mah7_ff, mbh7_ff;
   logic signed [ML_W-1:0]   mal7_in, mbl7_in, mal7_ff, mbl7_ff;
   logic signed [TEMP_W-1:0] temp7_ff;

   // Stage 8: final products
   logic signed [MH2_W-1:0]  a3_sum, b3_sum;
   logic signed [A3_W-1:0]   a3_ff, b3_ff;
   logic signed [TEMP_W-1:0] temp8_ff;

   // Stage 3
   assign ma3_in = MA_W'(coef_i.c30 * p_i);
   assign mb3_in = MA_W'(coef_i.c21 * p_i);
   assign mt3_in = MT_W'(coef_i.c1 * t_i);

   // Stage 4
   assign a1_in    = A1_W'(signed'({coef_i.c20, {Q_FRAC{1'b0}}})) + ma3_ff;
   assign b1_in    = A1_W'(signed'({coef_i.c11, {Q_FRAC{1'b0}}})) + mb3_ff;
   assign mt_rnd   = (mt3_ff + MT_W'(HALF_T)) >>> TEMP_SHIFT;
   assign temp4_in = TEMP_W'(signed'({coef_i.c0, {TEMP_C0_SHFT{1'b0}}}))
                   + signed'(mt_rnd[TEMP_W-1:0]);

   // Stage 5: high part signed, low part unsigned
   assign mah5_in = MH1_W'(signed'(a1_ff[A1_W-1:Q_FRAC]) * p4_ff);
   assign mal5_in = ML_W'(signed'({1'b0, a1_ff[Q_FRAC-1:0]}) * p4_ff);
   assign mbh5_in = MH1_W'(signed'(b1_ff[A1_W-1:Q_FRAC]) * p4_ff);
   assign mbl5_in = ML_W'(signed'({1'b0, b1_ff[Q_FRAC-1:0]}) * p4_ff);

   // Stage 6: recombine with the low part rounded to Q24
   assign a2_sum = ML_W'(signed'({coef_i.c10, {Q_FRAC{1'b0}}})) + ML_W'(mah5_ff)
                 + ((mal5_ff + ML_W'(HALF_Q)) >>> Q_FRAC);
   assign b2_sum = ML_W'(signed'({coef_i.c01, {Q_FRAC{1'b0}}})) + ML_W'(mbh5_ff)
                 + ((mbl5_ff + ML_W'(HALF_Q)) >>> Q_FRAC);

   // Stage 7
   assign mah7_in = MH2_W'(signed'(a2_ff[A2_W-1:Q_FRAC]) * p6_ff);
   assign mal7_in = ML_W'(signed'({1'b0, a2_ff[Q_FRAC-1:0]}) * p6_ff);
   assign mbh7_in = MH2_W'(signed'(b2_ff[A2_W-1:Q_FRAC]) * t6_ff);
   assign mbl7_in = ML_W'(signed'({1'b0, b2_ff[Q_FRAC-1:0]}) * t6_ff);

   // Stage 8
   assign a3_sum = mah7_ff + MH2_W'((mal7_ff + ML_W'(HALF_Q)) >>> Q_FRAC);
   assign b3_sum = mbh7_ff + MH2_W'((mbl7_ff + ML_W'(HALF_Q)) >>> Q_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en_i) begin
         v_ff <= {v_ff[4:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         ma3_ff   <= ma3_in;
         mb3_ff   <= mb3_in;
         mt3_ff   <= mt3_in;
         p3_ff    <= p_i;
         t3_ff    <= t_i;

         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         temp4_ff <= temp4_in;
         p4_ff    <= p3_ff;
         t4_ff    <= t3_ff;

         mah5_ff  <= mah5_in;
         mal5_ff  <= mal5_in;
         mbh5_ff  <= mbh5_in;
         mbl5_ff  <= mbl5_in;
         temp5_ff <= temp4_ff;
         p5_ff    <= p4_ff;
         t5_ff    <= t4_ff;

         a2_ff    <= a2_sum[A2_W-1:0];
         b2_ff    <= b2_sum[A2_W-1:0];
         temp6_ff <= temp5_ff;
         p6_ff    <= p5_ff;
         t6_ff    <= t5_ff;

         mah7_ff  <= mah7_in;
         mal7_ff  <= mal7_in;
         mbh7_ff  <= mbh7_in;
         mbl7_ff  <= mbl7_in;
         temp7_ff <= temp6_ff;

         a3_ff    <= a3_sum[A3_W-1:0];
         b3_ff    <= b3_sum[A3_W-1:0];
         temp8_ff <= temp7_ff;
      end
   end

   assign valid_o = v_ff[5];
   assign temp_o  = temp8_ff;
   assign a3_o    = a3_ff;
   assign b3_o    = b3_ff;

endmodule

>>> tb/sv/tb_baro_pressure_temp_compensation_core.sv
module tb_baro_pressure_temp_compensation_core;
   import bpc_pkg::*;

   // Raw sample width on the bus and in the block
   localparam int RAW_W = 24;
   // Register writes to this index are dropped by the block
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int NUM_REGS = 7;

   // Coefficient sets used by the directed part
   localparam logic [1:0] SET_RESET        = 2'd0;
   localparam logic [1:0] SET_OFFSETS_ONLY = 2'd1;
   localparam logic [1:0] SET_ALL_MAX      = 2'd2;
   localparam logic [1:0] SET_ALL_MIN      = 2'd3;

   localparam int NUM_PROBES      = 20;
   localparam int NUM_PHASES      = 14;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_PHASE      = 3;
   localparam int PAUSE_PHASE     = 5;
   localparam int HOLD_CYCLES     = 300;
   localparam int PIPE_LATENCY    = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 40;

   typedef logic signed [127:0] wide_type;
   localparam wide_type Q_UNIT = wide_type'(1) <<< Q_FRAC;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic signed [PRES_W-1:0] pressure;
      logic                     saturated;
   } compensated_type;

   typedef struct packed {
      logic [1:0]       coef_set;
      logic [RAW_W-1:0] raw_p;
      logic [RAW_W-1:0] raw_t;
      logic             known;
      compensated_type  res;
   } probe_type;

   localparam compensated_type ZERO_RES = '0;
   localparam compensated_type OFFSET_RES = '{-26'sd262144, -40'sd33554432, 1'b0};

   // Directed probes: typed results where the coefficients make them obvious
   probe_type probes [0:NUM_PROBES-1] = '{
      '{SET_RESET, 24'h7FFFFF, 24'h7FFFFF, 1'b1, ZERO_RES},
      '{SET_RESET, 24'h800000, 24'h800000, 1'b1, ZERO_RES},
      '{SET_RESET, 24'h000000, 24'h000000, 1'b1, ZERO_RES},
      '{SET_RESET, 24'hFFFFFF, 24'h000001, 1'b1, ZERO_RES},
      '{SET_OFFSETS_ONLY, 24'h7FFFFF, 24'h800000, 1'b1, OFFSET_RES},
      '{SET_OFFSETS_ONLY, 24'h000000, 24'h000000, 1'b1, OFFSET_RES},
      '{SET_ALL_MAX, 24'h7FFFFF, 24'h7FFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'h800000, 24'h800000, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'h7FFFFF, 24'h800000, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'h800000, 24'h7FFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'h000000, 24'h000000, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'hFFFFFF, 24'hFFFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MAX, 24'h000001, 24'h000001, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h7FFFFF, 24'h7FFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h800000, 24'h800000, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h7FFFFF, 24'h800000, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h800000, 24'h7FFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h000000, 24'h000000, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'hFFFFFF, 24'hFFFFFF, 1'b0, ZERO_RES},
      '{SET_ALL_MIN, 24'h000001, 24'h000001, 1'b0, ZERO_RES}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // [23:0] raw_pressure, [47:24] raw_temperature
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [25:0] temperature_out, [65:26] pressure_out, zeros
   logic        rsp_tuser;    // [0] saturated
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   // Copy of the coefficient registers as the block should hold them
   logic [31:0]     reg_shadow [0:NUM_REGS-1];
   logic [31:0]     staged [0:NUM_REGS-1];
   compensated_type pending_results [$];

   int err_count = 0;
   int n_checked = 0;
   int n_sent = 0;
   int n_settings = 1;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   baro_pressure_temp_compensation_core #(.RAW_WIDTH(RAW_W)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic wide_type sext(input logic [31:0] v, input int w);
      wide_type x;
      x = wide_type'(v) & ((wide_type'(1) <<< w) - 1);
      if (x[w-1]) x = x - (wide_type'(1) <<< w);
      return x;
   endfunction

   // round half up of x / 2^s
   function automatic wide_type round_shift(input wide_type x, input int s);
      return (x + (wide_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic wide_type osr_factor(input logic [2:0] code);
      case (code)
         3'd0: return 524288;
         3'd1: return 1572864;
         3'd2: return 3670016;
         3'd3: return 7864320;
         3'd4: return 253952;
         3'd5: return 516096;
         3'd6: return 1040384;
         default: return 2088960;
      endcase
   endfunction

   // raw / factor as a Q24 value, through the rounded reciprocal of the factor
   function automatic wide_type scale_sample(input logic [RAW_W-1:0] raw,
                                             input logic [2:0] code);
      wide_type f, recip;
      f = osr_factor(code);
      recip = ((wide_type'(1) <<< 48) + (f >>> 1)) / f;
      return round_shift(sext(raw, RAW_W) * recip, Q_FRAC);
   endfunction

   function automatic compensated_type compensate(input logic [RAW_W-1:0] raw_p,
                                                  input logic [RAW_W-1:0] raw_t);
      wide_type c0, c1, c00, c10, c01, c11, c20, c21, c30;
      wide_type p, t, temp, a, b, pres;
      compensated_type res;
      c0  = sext(reg_shadow[REG_TEMP_OFFSET_GAIN] >> 12, 12);
      c1  = sext(reg_shadow[REG_TEMP_OFFSET_GAIN], 12);
      c00 = sext(reg_shadow[REG_PRESSURE_OFFSET], 20);
      c10 = sext(reg_shadow[REG_PRESSURE_LINEAR], 20);
      c01 = sext(reg_shadow[REG_CROSS_TERMS] >> 16, 16);
      c11 = sext(reg_shadow[REG_CROSS_TERMS], 16);
      c20 = sext(reg_shadow[REG_QUADRATIC_TERMS] >> 16, 16);
      c21 = sext(reg_shadow[REG_QUADRATIC_TERMS], 16);
      c30 = sext(reg_shadow[REG_CUBIC_TERM], 16);
      p = scale_sample(raw_p, reg_shadow[REG_OVERSAMPLING_SEL][5:3]);
      t = scale_sample(raw_t, reg_shadow[REG_OVERSAMPLING_SEL][2:0]);

      temp = c0 * 128 + round_shift(c1 * t, TEMP_SHIFT);

      // Horner chain, each product of a partial term with p or t rounded back to Q24
      a = c20 * Q_UNIT + c30 * p;
      a = c10 * Q_UNIT + round_shift(a * p, Q_FRAC);
      a = round_shift(a * p, Q_FRAC);
      b = c11 * Q_UNIT + c21 * p;
      b = c01 * Q_UNIT + round_shift(b * p, Q_FRAC);
      b = round_shift(b * t, Q_FRAC);
      pres = round_shift(c00 * Q_UNIT + a + b, PRES_SHIFT);

      res.saturated = 1'b0;
      if (pres > PRES_MAX) begin
         pres = PRES_MAX;
         res.saturated = 1'b1;
      end
      if (pres < PRES_MIN) begin
         pres = PRES_MIN;
         res.saturated = 1'b1;
      end
      res.temperature = temp[TEMP_W-1:0];
      res.pressure = pres[PRES_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- registers

   function automatic int reg_width(input logic [2:0] idx);
      case (idx)
         REG_TEMP_OFFSET_GAIN: return 24;
         REG_PRESSURE_OFFSET, REG_PRESSURE_LINEAR: return 20;
         REG_CROSS_TERMS, REG_QUADRATIC_TERMS: return 32;
         REG_CUBIC_TERM: return 16;
         default: return 6;
      endcase
   endfunction

   function automatic logic [31:0] reg_mask(input int w);
      return (w >= 32) ? 32'hFFFFFFFF : ((32'h1 << w) - 32'h1);
   endfunction

   // Largest or most negative value of every packed coefficient
   function automatic logic [31:0] extreme_value(input bit negative, input logic [2:0] idx);
      case (idx)
         REG_TEMP_OFFSET_GAIN: return negative ? 32'h800800 : 32'h7FF7FF;
         REG_PRESSURE_OFFSET, REG_PRESSURE_LINEAR: return negative ? 32'h80000 : 32'h7FFFF;
         REG_CROSS_TERMS, REG_QUADRATIC_TERMS: return negative ? 32'h80008000 : 32'h7FFF7FFF;
         REG_CUBIC_TERM: return negative ? 32'h8000 : 32'h7FFF;
         default: return negative ? 32'h3F : 32'h0;
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx != REG_UNMAPPED) reg_shadow[idx] = data & reg_mask(reg_width(idx));
   endtask

   // Write the staged set with junk above each register's width, plus a dropped write
   task automatic apply_staged();
      logic [31:0] data;
      int w;
      write_reg(REG_UNMAPPED, $urandom);
      for (int i = 0; i < NUM_REGS; i++) begin
         w = reg_width(3'(i));
         data = staged[i];
         if (w < 32) data = data | ($urandom << w);
         write_reg(3'(i), data);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic stage_directed(input logic [1:0] coef_set);
      for (int i = 0; i < NUM_REGS; i++) staged[i] = 32'd0;
      case (coef_set)
         SET_OFFSETS_ONLY: begin
            // c0 and c00 at their most negative, everything else zero
            staged[REG_TEMP_OFFSET_GAIN] = 32'h800000;
            staged[REG_PRESSURE_OFFSET]  = 32'h80000;
         end
         SET_ALL_MAX: begin
            for (int i = 0; i < NUM_REGS; i++) staged[i] = extreme_value(1'b0, 3'(i));
            staged[REG_OVERSAMPLING_SEL] = 32'o44;
         end
         SET_ALL_MIN: begin
            for (int i = 0; i < NUM_REGS; i++) staged[i] = extreme_value(1'b1, 3'(i));
            staged[REG_OVERSAMPLING_SEL] = 32'o47;
         end
         default: ;
      endcase
   endtask

   // Random coefficients, often at an extreme; the phase number walks all codes
   task automatic stage_random(input int ph);
      int pick;
      logic [2:0] p_code, t_code;
      for (int i = 0; i < NUM_REGS; i++) begin
         pick = $urandom_range(0, 3);
         if (pick == 0) staged[i] = extreme_value(1'b0, 3'(i));
         else if (pick == 1) staged[i] = extreme_value(1'b1, 3'(i));
         else staged[i] = $urandom & reg_mask(reg_width(3'(i)));
      end
      p_code = 3'(ph);
      t_code = 3'(ph * 3 + 1);
      staged[REG_OVERSAMPLING_SEL] = {26'd0, p_code, t_code};
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [RAW_W-1:0] random_raw();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 512)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                            input logic known, input compensated_type typed_res);
      req_tdata  <= {raw_t, raw_p};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer done at this edge
      if (known) pending_results.push_back(typed_res);
      else pending_results.push_back(compensate(raw_p, raw_t));
      n_sent++;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("MISMATCH %s on result %0d: got %0d, expected %0d",
                  what, n_checked, got, want);
   endtask

   always @(posedge clock) begin : result_check
      compensated_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", longint'(signed'(rsp_tdata[25:0])), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[25:0] !== want.temperature)
               report_mismatch("temperature", longint'(signed'(rsp_tdata[25:0])),
                               longint'(signed'(want.temperature)));
            if (rsp_tdata[65:26] !== want.pressure)
               report_mismatch("pressure", longint'(signed'(rsp_tdata[65:26])),
                               longint'(signed'(want.pressure)));
            if (rsp_tuser !== want.saturated)
               report_mismatch("saturated", longint'(rsp_tuser), longint'(want.saturated));
         end
         n_checked++;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin : rsp_ready_driver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_baro_pressure_temp_compensation_core: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : main_flow
      logic [1:0] cur_set;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      for (int i = 0; i < NUM_REGS; i++) reg_shadow[i] = 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed probes, starting on the reset coefficients
      cur_set = SET_RESET;
      for (int r = 0; r < NUM_PROBES; r++) begin
         if (probes[r].coef_set != cur_set) begin
            drain();
            cur_set = probes[r].coef_set;
            stage_directed(cur_set);
            apply_staged();
         end
         send_pair(probes[r].raw_p, probes[r].raw_t, probes[r].known, probes[r].res);
      end

      // Random phases, each with its own coefficients and oversampling codes
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         stage_random(ph);
         apply_staged();
         idle_on = (ph < NUM_PHASES - 2) && (ph % 3 != 2);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (ph == HOLD_PHASE && k == 10) hold_request = 1'b1;
            if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) drain();
            send_pair(random_raw(), random_raw(), 1'b0, ZERO_RES);
         end
      end

      drain();
      repeat (3 * PIPE_LATENCY) @(posedge clock);

      $display("covered %0d sample pairs under %0d coefficient settings, all oversampling codes",
               n_sent, n_settings);
      $display("checked %0d results, %0d mismatches", n_checked, err_count);
      if (err_count == 0) begin
         $display("tb_baro_pressure_temp_compensation_core: done, clean");
      end else begin
         $display("tb_baro_pressure_temp_compensation_core: done, errors");
      end
      $finish;
   end

endmodule

>>> baro_pressure_temp_compensation_core.f
hdl/bpc_pkg.sv
hdl/bpc_scale.sv
hdl/bpc_poly.sv
hdl/baro_pressure_temp_compensation_core.sv
tb/sv/tb_baro_pressure_temp_compensation_core.sv
